// File: hdl/byte_stream_reassembler_unit_assert.svh
// ----------------------------------------------------------------------------
// byte stream reassembler assertion macros
// clocked implication checks with an active-low reset guard (disable iff)
// ----------------------------------------------------------------------------
`ifndef BYTE_STREAM_REASSEMBLER_UNIT_ASSERT_SVH
`define BYTE_STREAM_REASSEMBLER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg
// shared constants and the control bundle broadcast to the slot cells
// ----------------------------------------------------------------------------
`default_nettype none

package bsr_pkg;

    // default window size in bytes
    localparam int BSR_CAPACITY = 64;
    // offset width, holds 0 .. BSR_CAPACITY
    localparam int OFF_W = 7;

    typedef struct packed {
        logic             shift;      // every cell takes its upper neighbour
        logic             ins;        // store wr_data at ins_off if empty
        logic [OFF_W-1:0] ins_off;
        logic             trunc;      // drop every cell at or above trunc_off
        logic [OFF_W-1:0] trunc_off;
        logic [7:0]       wr_data;
    } bsr_cell_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/bsr_cell.sv
// ----------------------------------------------------------------------------
// bsr_cell
// one window slot: valid mark and data byte, shifts down towards offset zero
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_cell #(
    parameter int POS = 0
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire bsr_pkg::bsr_cell_ctrl_t ctrl,
    input  wire logic                    nbr_valid,
    input  wire logic [7:0]              nbr_data,
    output logic                         valid,
    output logic [7:0]                   data
);
    import bsr_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       ins_hit, trunc_hit;

    assign ins_hit   = ctrl.ins && (ctrl.ins_off == OFF_W'(POS)) && !valid_reg;
    assign trunc_hit = ctrl.trunc && (OFF_W'(POS) >= ctrl.trunc_off);

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.shift) begin
            valid_next = nbr_valid;
            data_next  = nbr_data;
        end else if (trunc_hit) begin
            valid_next = 1'b0;
        end else if (ins_hit) begin
            valid_next = 1'b1;
            data_next  = ctrl.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire

// File: hdl/bsr_run_count.sv
// ----------------------------------------------------------------------------
// bsr_run_count
// two-level tree: stored byte count and length of the in-order run from slot 0
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_run_count #(
    parameter int CAPACITY = bsr_pkg::BSR_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic                aclk,
    input  wire logic [CAPACITY-1:0] valid_vec,
    output logic [CNT_W-1:0]         pop,
    output logic [CNT_W-1:0]         run
);
    localparam int NGRP  = (CAPACITY + 7) / 8;
    localparam int PAD_W = NGRP * 8;

    logic [PAD_W-1:0] vpad;
    logic [3:0]       g_pop_reg [NGRP];
    logic [3:0]       g_lead_reg[NGRP];
    logic [3:0]       g_pop_next [NGRP];
    logic [3:0]       g_lead_next[NGRP];

    assign vpad = PAD_W'(valid_vec);

    // first level: per group of eight slots
    always_comb begin
        logic [3:0] p;
        logic [3:0] l;
        logic       r;
        for (int g = 0; g < NGRP; g++) begin
            p = '0;
            l = '0;
            r = 1'b1;
            for (int b = 0; b < 8; b++) begin
                p = p + 4'(vpad[g*8+b]);
                if (r && vpad[g*8+b]) begin
                    l = l + 4'd1;
                end else begin
                    r = 1'b0;
                end
            end
            g_pop_next[g]  = p;
            g_lead_next[g] = l;
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < NGRP; g++) begin
            g_pop_reg[g]  <= g_pop_next[g];
            g_lead_reg[g] <= g_lead_next[g];
        end
    end

    // second level: combine the groups
    always_comb begin
        logic [CNT_W-1:0] tot;
        logic [CNT_W-1:0] rn;
        logic             full;
        tot  = '0;
        rn   = '0;
        full = 1'b1;
        for (int g = 0; g < NGRP; g++) begin
            tot = tot + CNT_W'(g_pop_reg[g]);
            if (full) begin
                rn = rn + CNT_W'(g_lead_reg[g]);
            end
            full = full && (g_lead_reg[g] == 4'd8);
        end
        pop = tot;
        run = rn;
    end

endmodule

`default_nettype wire

// File: hdl/byte_stream_reassembler_unit.sv
// ----------------------------------------------------------------------------
// byte_stream_reassembler_unit
// in-order reassembly of indexed stream bytes over a sliding window of slots
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                                   | tuser / tlast
//  --------+-----+-----------------------------------------+-------------------------
//  s_      | in  | byte_value[7:0], byte_index[39:8]       | has_byte / ends_stream
//  m_      | out | out_byte[7:0], pending_count[14:8]      | out_valid,
//          |     |                                         | stream_finished / last_of_run
//
//  one transaction in at a time: accept, run counting in ST_CNT1 and ST_CNT2, then
//  one result per released byte, or a single status-only result if none is released
//  each result lasts until m_tready; the slot chain shifts once per released byte
//  reset clears the valid marks of every cell at once, no clearing pass
//  s_tready is high only between items
//
`default_nettype none
`include "byte_stream_reassembler_unit_assert.svh"

module byte_stream_reassembler_unit #(
    parameter int CAPACITY = bsr_pkg::BSR_CAPACITY
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input transactions
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // byte_value[7:0], byte_index[39:8]
    input  wire logic [0:0]  s_tuser,   // has_byte[0]
    input  wire logic        s_tlast,   // ends_stream
    // result transactions
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // out_byte[7:0], pending_count[14:8], zero[15]
    output logic [1:0]       m_tuser,   // out_valid[0], stream_finished[1]
    output logic             m_tlast    // last_of_run
);
    import bsr_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CNT1 = 4'b0010,
        ST_CNT2 = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // stream state
    logic [31:0]      exp_reg, exp_next;
    logic             end_known_reg, end_known_next;
    logic [31:0]      end_pos_reg, end_pos_next;
    logic             done_reg, done_next;
    // per-item result bookkeeping
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic [CNT_W-1:0] pend_reg, pend_next;

    // slot chain
    bsr_cell_ctrl_t   ctrl;
    logic             cell_valid[CAPACITY+1];
    logic [7:0]       cell_data [CAPACITY+1];
    logic [CAPACITY-1:0] valid_vec;

    logic [CNT_W-1:0] tree_pop, tree_run, run_eff;

    // input decode
    logic        s_acc, m_acc;
    logic        has_byte, ends_stream;
    logic [7:0]  byte_value;
    logic [31:0] byte_index, diff;
    logic        byte_ok;
    logic [32:0] end_e, end_diff;
    logic        end_ok;
    logic        has_out;

    assign has_byte    = s_tuser[0];
    assign ends_stream = s_tlast;
    assign byte_value  = s_tdata[7:0];
    assign byte_index  = s_tdata[39:8];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_acc    = m_tvalid && m_tready;
    assign has_out  = (remain_reg != '0);

    // byte inside the window, below any known end, not at the last index
    assign diff    = byte_index - exp_reg;
    assign byte_ok = has_byte && (byte_index >= exp_reg) && (diff < 32'(CAPACITY))
                     && (byte_index != '1)
                     && !(end_known_reg && (byte_index >= end_pos_reg));

    // end mark kept only if its position lies within the window
    assign end_e    = {1'b0, byte_index} + 33'(has_byte);
    assign end_diff = end_e - {1'b0, exp_reg};
    assign end_ok   = ends_stream && !end_known_reg && !end_e[32]
                      && (end_e >= {1'b0, exp_reg}) && (end_diff <= 33'(CAPACITY));

    // broadcast to the cells
    always_comb begin
        ctrl           = '0;
        ctrl.wr_data   = byte_value;
        ctrl.ins_off   = OFF_W'(diff);
        ctrl.trunc_off = OFF_W'(end_diff);
        if (s_acc && !done_reg) begin
            ctrl.ins   = byte_ok;
            ctrl.trunc = end_ok;
        end
        ctrl.shift = m_acc && has_out;
    end

    // slot 0 holds the byte at the expected index, upper cells feed down
    assign cell_valid[CAPACITY] = 1'b0;
    assign cell_data[CAPACITY]  = 8'd0;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        bsr_cell #(
            .POS (k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .nbr_valid (cell_valid[k+1]),
            .nbr_data  (cell_data[k+1]),
            .valid     (cell_valid[k]),
            .data      (cell_data[k])
        );
        assign valid_vec[k] = cell_valid[k];
    end

    // stored count and in-order run, ready in ST_CNT2
    bsr_run_count #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_run_count (
        .aclk      (aclk),
        .valid_vec (valid_vec),
        .pop       (tree_pop),
        .run       (tree_run)
    );

    // nothing is released once the stream has finished
    assign run_eff = done_reg ? '0 : tree_run;

    always_comb begin
        state_next     = state_reg;
        exp_next       = exp_reg;
        end_known_next = end_known_reg;
        end_pos_next   = end_pos_reg;
        done_next      = done_reg;
        remain_next    = remain_reg;
        pend_next      = pend_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (!done_reg && end_ok) begin
                        end_known_next = 1'b1;
                        end_pos_next   = end_e[31:0];
                    end
                    state_next = ST_CNT1;
                end
            end
            ST_CNT1: begin
                state_next = ST_CNT2;
            end
            ST_CNT2: begin
                // status after the whole run is known before the first result
                remain_next = run_eff;
                pend_next   = tree_pop - run_eff;
                if (end_known_reg && ((exp_reg + 32'(run_eff)) == end_pos_reg)) begin
                    done_next = 1'b1;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_acc) begin
                    if (has_out) begin
                        exp_next    = exp_reg + 32'd1;
                        remain_next = remain_reg - CNT_W'(1);
                    end
                    if (m_tlast) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            exp_reg       <= '0;
            end_known_reg <= 1'b0;
            end_pos_reg   <= '0;
            done_reg      <= 1'b0;
            remain_reg    <= '0;
            pend_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            exp_reg       <= exp_next;
            end_known_reg <= end_known_next;
            end_pos_reg   <= end_pos_next;
            done_reg      <= done_next;
            remain_reg    <= remain_next;
            pend_reg      <= pend_next;
        end
    end

    // result: slot 0 byte, or a status-only transaction when nothing was released
    assign m_tdata = {1'b0, 7'(pend_reg), (has_out ? cell_data[0] : 8'd0)};
    assign m_tuser = {done_reg, has_out};
    assign m_tlast = (remain_reg <= CNT_W'(1));

    // one item in flight: no input while results are pending
    `BSR_ASSERT_IMPL(a_idle_no_result, aclk, aresetn, s_tready, !m_tvalid)
    // an accepted item is followed by the counting cycles
    `BSR_ASSERT_NEXT(a_accept_counts, aclk, aresetn, s_acc, (state_reg == ST_CNT1))
    // a released byte always sits in a valid slot 0
    `BSR_ASSERT_IMPL(a_byte_from_valid, aclk, aresetn, (m_tvalid && m_tuser[0]),
                     cell_valid[0])
    // the finished flag never falls
    `BSR_ASSERT_NEXT(a_done_sticks, aclk, aresetn, done_reg, done_reg)
    // the final result of an item hands back to the input side
    `BSR_ASSERT_NEXT(a_last_returns, aclk, aresetn, (m_acc && m_tlast), s_tready)

endmodule

`default_nettype wire
